[hw/rtl/sdfe_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the delta frame encoder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sdfe_pkg;

  localparam int MAX_ELEMENTS           = 2;
  localparam int ELEMENTS_PER_FRAME_DEF = 2;

  localparam logic [7:0]  FRM_STX          = 8'h02;
  localparam logic [7:0]  FRM_ETX          = 8'h03;
  localparam logic [15:0] CRC_POLY         = 16'h1021;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [7:0]  MAX_FRAMES_RESET = 8'd5;

  // One record as it moves down the pipeline
  typedef struct packed {
    logic [7:0]                   key_id;
    logic [7:0]                   cycle_index;
    logic [MAX_ELEMENTS-1:0][15:0] delta;
    logic [15:0]                  crc;
  } rec_t;

  // CRC-16/CCITT-FALSE update over one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // The start byte is fixed, so fold it into the seed
  localparam logic [15:0] CRC_AFTER_STX = crc_byte(CRC_INIT, FRM_STX);

endpackage

`default_nettype wire

[hw/rtl/sdfe_delta.sv]
// First pipeline stage: frame-limit filter, element clamp and absolute differences.
// Depends on sdfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdfe_delta
  import sdfe_pkg::*;
#(
  parameter int ELEMENTS = ELEMENTS_PER_FRAME_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  max_frames,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_key_id,
  input  wire logic [7:0]  in_cycle_index,
  input  wire logic [1:0]  in_element_count,
  input  wire logic [15:0] in_filtered_count_0,
  input  wire logic [15:0] in_baseline_0,
  input  wire logic [15:0] in_filtered_count_1,
  input  wire logic [15:0] in_baseline_1,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output rec_t             dn_rec
);

  logic        valid_r;
  rec_t        rec_r;
  rec_t        rec_nxt;
  logic [1:0]  cnt;
  logic [15:0] fc [MAX_ELEMENTS];
  logic [15:0] bl [MAX_ELEMENTS];

  assign in_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_rec   = rec_r;

  always_comb begin
    fc[0] = in_filtered_count_0;
    bl[0] = in_baseline_0;
    fc[1] = in_filtered_count_1;
    bl[1] = in_baseline_1;
    cnt   = (in_element_count > 2'(ELEMENTS)) ? 2'(ELEMENTS) : in_element_count;
    rec_nxt             = '0;
    rec_nxt.key_id      = in_key_id;
    rec_nxt.cycle_index = in_cycle_index;
    for (int e = 0; e < MAX_ELEMENTS; e++) begin
      if (e < ELEMENTS && 2'(e) < cnt) begin
        rec_nxt.delta[e] = (fc[e] > bl[e]) ? (fc[e] - bl[e]) : (bl[e] - fc[e]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      // drop cycles at or past the frame limit
      valid_r <= in_valid && (in_cycle_index < max_frames);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rec_r <= rec_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sdfe_crc_stage.sv]
// One CRC pipeline stage: folds two frame bytes into the running CRC;
// a STEP above ELEMENTS carries it unchanged. Depends on sdfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdfe_crc_stage
  import sdfe_pkg::*;
#(
  parameter int ELEMENTS = ELEMENTS_PER_FRAME_DEF,
  parameter int STEP     = 0
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic up_valid,
  output logic      up_ready,
  input  wire rec_t up_rec,
  output logic      dn_valid,
  input  wire logic dn_ready,
  output rec_t      dn_rec
);

  logic valid_r;
  rec_t rec_r;
  rec_t rec_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_rec   = rec_r;

  generate
    if (STEP == 0) begin : g_head
      // start byte is in the seed; add id and cycle index
      always_comb begin
        rec_nxt     = up_rec;
        rec_nxt.crc = crc_byte(crc_byte(CRC_AFTER_STX, up_rec.key_id), up_rec.cycle_index);
      end
    end else if (STEP <= ELEMENTS) begin : g_delta
      always_comb begin
        rec_nxt     = up_rec;
        rec_nxt.crc = crc_byte(crc_byte(up_rec.crc, up_rec.delta[STEP-1][15:8]),
                               up_rec.delta[STEP-1][7:0]);
      end
    end else begin : g_hold
      // element not in the frame: carry the CRC unchanged
      always_comb begin
        rec_nxt = up_rec;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      rec_r <= rec_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sdfe_serializer.sv]
// Frame store and byte serializer: assembles the frame and emits it one byte per transaction.
// Depends on sdfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdfe_serializer
  import sdfe_pkg::*;
#(
  parameter int ELEMENTS = ELEMENTS_PER_FRAME_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       up_valid,
  output logic            up_ready,
  input  wire rec_t       up_rec,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_frame_byte,
  output logic            out_frame_last
);

  localparam int              FRM_LEN = 2 * ELEMENTS + 6;
  localparam int              POS_W   = $clog2(FRM_LEN);
  localparam logic [POS_W-1:0] LAST   = POS_W'(FRM_LEN - 1);

  logic [7:0]       frame_r   [FRM_LEN];
  logic [7:0]       frame_nxt [FRM_LEN];
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             busy_r;
  logic             busy_nxt;
  logic             last;
  logic             load;
  logic             out_take;

  assign last           = (pos_r == LAST);
  assign out_take       = busy_r && out_ready;
  assign up_ready       = !busy_r || (out_ready && last);
  assign load           = up_valid && up_ready;
  assign out_valid      = busy_r;
  assign out_frame_byte = frame_r[pos_r];
  assign out_frame_last = last;

  always_comb begin
    frame_nxt[0] = FRM_STX;
    frame_nxt[1] = up_rec.key_id;
    frame_nxt[2] = up_rec.cycle_index;
    for (int e = 0; e < ELEMENTS; e++) begin
      frame_nxt[3 + 2 * e] = up_rec.delta[e][15:8];
      frame_nxt[4 + 2 * e] = up_rec.delta[e][7:0];
    end
    frame_nxt[FRM_LEN - 3] = up_rec.crc[15:8];
    frame_nxt[FRM_LEN - 2] = up_rec.crc[7:0];
    frame_nxt[FRM_LEN - 1] = FRM_ETX;
  end

  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    if (out_take) begin
      if (last) begin
        busy_nxt = 1'b0;
        pos_nxt  = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      pos_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= frame_nxt;
    end
  end

  a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> pos_r == '0)
    else $error("serializer idle with a nonzero byte position");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST)
    else $error("byte position beyond the frame");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !last) |=> busy_r && pos_r == $past(pos_r) + POS_W'(1))
    else $error("byte position did not advance after a transaction");

  a_load_restart: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> busy_r && pos_r == '0)
    else $error("new frame did not start at byte zero");

endmodule

`default_nettype wire

[hw/rtl/sensor_delta_frame_encoder_top.sv]
// Top level of the sensor delta frame encoder: configuration register and pipeline.
// Depends on sdfe_pkg, sdfe_delta, sdfe_crc_stage and sdfe_serializer.
//
// Usage:
//  - Input channel (in_valid/in_ready): one scan-cycle record per transaction.
//    Records whose cycle index is at or above max_frames are consumed and dropped.
//  - Output channel (out_valid/out_ready): one frame byte per transaction, ten
//    bytes per record (STX, id, cycle, two deltas, CRC-16 high/low, ETX);
//    out_frame_last marks the ETX byte.
//  - cfg_wr_en/cfg_wr_data write max_frames (reset value 5); write only while idle.
//  - Path: a record passes the delta stage and three CRC stages, then is loaded
//    into the serializer frame store, which presents the first byte of its frame.
//  - Byte rate: the serializer emits one byte per cycle while out_ready is high;
//    four pipeline stages (delta, three CRC steps) hold up to four further
//    records, so the input keeps flowing while a frame drains.
//  - Receiver stall: the current byte holds, backpressure propagates stage by
//    stage and in_ready falls once every stage is full; nothing is lost.
//  - Reset (synchronous, rst_n low): all stages empty, serializer idle, max_frames
//    back to 5.
`timescale 1ns / 1ps
`default_nettype none

module sensor_delta_frame_encoder_top
  import sdfe_pkg::*;
#(
  parameter int ELEMENTS_PER_FRAME = ELEMENTS_PER_FRAME_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_key_id,
  input  wire logic [7:0]  in_cycle_index,
  input  wire logic [1:0]  in_element_count,
  input  wire logic [15:0] in_filtered_count_0,
  input  wire logic [15:0] in_baseline_0,
  input  wire logic [15:0] in_filtered_count_1,
  input  wire logic [15:0] in_baseline_1,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_frame_byte,
  output logic             out_frame_last
);

  logic [7:0] max_frames_r;

  // stage handshakes: index k is the output of stage k
  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  logic s3_valid, s3_ready;
  logic s4_valid, s4_ready;
  rec_t s1_rec, s2_rec, s3_rec, s4_rec;

  // frame limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frames_r <= MAX_FRAMES_RESET;
    end else if (cfg_wr_en) begin
      max_frames_r <= cfg_wr_data;
    end
  end

  // filter, clamp and absolute differences
  sdfe_delta #(.ELEMENTS(ELEMENTS_PER_FRAME)) u_delta (
    .clk                 (clk),
    .rst_n               (rst_n),
    .max_frames          (max_frames_r),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_key_id           (in_key_id),
    .in_cycle_index      (in_cycle_index),
    .in_element_count    (in_element_count),
    .in_filtered_count_0 (in_filtered_count_0),
    .in_baseline_0       (in_baseline_0),
    .in_filtered_count_1 (in_filtered_count_1),
    .in_baseline_1       (in_baseline_1),
    .dn_valid            (s1_valid),
    .dn_ready            (s1_ready),
    .dn_rec              (s1_rec)
  );

  // CRC over id and cycle index
  sdfe_crc_stage #(.ELEMENTS(ELEMENTS_PER_FRAME), .STEP(0)) u_crc_head (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_rec   (s1_rec),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_rec   (s2_rec)
  );

  // CRC over element zero's delta
  sdfe_crc_stage #(.ELEMENTS(ELEMENTS_PER_FRAME), .STEP(1)) u_crc_el0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_rec   (s2_rec),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_rec   (s3_rec)
  );

  // CRC over element one's delta; passes the CRC through when ELEMENTS_PER_FRAME is below two
  sdfe_crc_stage #(.ELEMENTS(ELEMENTS_PER_FRAME), .STEP(2)) u_crc_el1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s3_ready),
    .up_rec   (s3_rec),
    .dn_valid (s4_valid),
    .dn_ready (s4_ready),
    .dn_rec   (s4_rec)
  );

  // assemble the frame and drain it byte by byte
  sdfe_serializer #(.ELEMENTS(ELEMENTS_PER_FRAME)) u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (s4_valid),
    .up_ready       (s4_ready),
    .up_rec         (s4_rec),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_frame_last (out_frame_last)
  );

endmodule

`default_nettype wire

[dv/sdfe_frame_checker.sv]
// Frame checker for the sensor delta frame encoder: predicts every frame byte from the
// accepted records and compares it with each output transaction. Depends on sdfe_pkg.
`timescale 1ns / 1ps

module sdfe_frame_checker
  import sdfe_pkg::*;
#(
  parameter int ELEMENTS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_key_id,
  input  logic [7:0]  in_cycle_index,
  input  logic [1:0]  in_element_count,
  input  logic [15:0] in_filtered_count_0,
  input  logic [15:0] in_baseline_0,
  input  logic [15:0] in_filtered_count_1,
  input  logic [15:0] in_baseline_1,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_frame_byte,
  input  logic        out_frame_last,
  output int          mismatches,
  output int          bytes_pending,
  output int          bytes_checked,
  output int          records_dropped
);

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } frame_beat_t;

  frame_beat_t pending_frame_bytes[$];
  logic [7:0]  frame_limit;

  function automatic logic [15:0] abs_delta(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // CRC-16, MSB first, over the seven header bytes (first byte in the top bits)
  function automatic logic [15:0] header_crc(input logic [55:0] hdr);
    logic [15:0] acc;
    acc = CRC_INIT;
    for (int i = 0; i < 7; i++) begin
      acc = acc ^ {hdr[55 - 8 * i -: 8], 8'h00};
      for (int b = 0; b < 8; b++) begin
        acc = acc[15] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
      end
    end
    return acc;
  endfunction

  task automatic build_frame(input logic [7:0] id, input logic [7:0] cyc,
                             input logic [1:0] cnt,
                             input logic [15:0] fc0, input logic [15:0] bl0,
                             input logic [15:0] fc1, input logic [15:0] bl1);
    int          used;
    logic [15:0] d0;
    logic [15:0] d1;
    logic [55:0] hdr;
    logic [15:0] crc;
    used = (int'(cnt) > ELEMENTS) ? ELEMENTS : int'(cnt);
    d0   = (used > 0) ? abs_delta(fc0, bl0) : 16'h0000;
    d1   = (used > 1) ? abs_delta(fc1, bl1) : 16'h0000;
    hdr  = {FRM_STX, id, cyc, d0, d1};
    crc  = header_crc(hdr);
    for (int i = 0; i < 7; i++) begin
      pending_frame_bytes.push_back({hdr[55 - 8 * i -: 8], 1'b0});
    end
    pending_frame_bytes.push_back({crc[15:8], 1'b0});
    pending_frame_bytes.push_back({crc[7:0], 1'b0});
    pending_frame_bytes.push_back({FRM_ETX, 1'b1});
  endtask

  initial begin
    mismatches      = 0;
    bytes_pending   = 0;
    bytes_checked   = 0;
    records_dropped = 0;
    frame_limit     = MAX_FRAMES_RESET;
  end

  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst_n) begin
      frame_limit = MAX_FRAMES_RESET;
      pending_frame_bytes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_frame_bytes.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected frame byte %02h last %0b",
                     $realtime, out_frame_byte, out_frame_last);
          mismatches++;
        end else begin
          want = pending_frame_bytes.pop_front();
          if (want.frame_byte !== out_frame_byte || want.frame_last !== out_frame_last) begin
            if (mismatches < 10)
              $display("%0t: frame byte mismatch: expected %02h last %0b, got %02h last %0b",
                       $realtime, want.frame_byte, want.frame_last,
                       out_frame_byte, out_frame_last);
            mismatches++;
          end
          bytes_checked++;
        end
      end
      if (in_valid && in_ready) begin
        if (in_cycle_index >= frame_limit)
          records_dropped++;
        else
          build_frame(in_key_id, in_cycle_index, in_element_count,
                      in_filtered_count_0, in_baseline_0,
                      in_filtered_count_1, in_baseline_1);
      end
      if (cfg_wr_en)
        frame_limit = cfg_wr_data;
    end
    bytes_pending = pending_frame_bytes.size();
  end

endmodule

[dv/tb_sensor_delta_frame_encoder_top.sv]
// Testbench top for the sensor delta frame encoder: clock, reset, record and ready stimulus,
// frame limit writes and the verdict. Depends on sdfe_pkg, sdfe_frame_checker and the RTL.
`timescale 1ns / 1ps

module tb_sensor_delta_frame_encoder_top
  import sdfe_pkg::*;
();

  // Cycles to let a dropped record clear the pipeline before a limit write
  localparam int DRAIN_GUARD = 30;
  // Length of the long receiver hold-off that fills every stage
  localparam int HOLD_CYCLES = 160;
  // Hard stop, in nanoseconds
  localparam int TIMEOUT_NS  = 1_000_000;

  typedef struct packed {
    logic [7:0]  key_id;
    logic [7:0]  cycle_index;
    logic [1:0]  element_count;
    logic [15:0] filtered_count_0;
    logic [15:0] baseline_0;
    logic [15:0] filtered_count_1;
    logic [15:0] baseline_1;
  } scan_rec_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_key_id;
  logic [7:0]  in_cycle_index;
  logic [1:0]  in_element_count;
  logic [15:0] in_filtered_count_0;
  logic [15:0] in_baseline_0;
  logic [15:0] in_filtered_count_1;
  logic [15:0] in_baseline_1;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_frame_byte;
  logic        out_frame_last;

  int mismatches;
  int bytes_pending;
  int bytes_checked;
  int records_dropped;

  // Stimulus bookkeeping
  int         records_sent;
  int         limit_writes;
  int         hold_requests;
  int         holds_done;
  bit         tx_idle;
  bit         rx_idle;
  logic [7:0] frame_limit_now;

  sensor_delta_frame_encoder_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_key_id           (in_key_id),
    .in_cycle_index      (in_cycle_index),
    .in_element_count    (in_element_count),
    .in_filtered_count_0 (in_filtered_count_0),
    .in_baseline_0       (in_baseline_0),
    .in_filtered_count_1 (in_filtered_count_1),
    .in_baseline_1       (in_baseline_1),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_byte      (out_frame_byte),
    .out_frame_last      (out_frame_last)
  );

  sdfe_frame_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_key_id           (in_key_id),
    .in_cycle_index      (in_cycle_index),
    .in_element_count    (in_element_count),
    .in_filtered_count_0 (in_filtered_count_0),
    .in_baseline_0       (in_baseline_0),
    .in_filtered_count_1 (in_filtered_count_1),
    .in_baseline_1       (in_baseline_1),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_byte      (out_frame_byte),
    .out_frame_last      (out_frame_last),
    .mismatches          (mismatches),
    .bytes_pending       (bytes_pending),
    .bytes_checked       (bytes_checked),
    .records_dropped     (records_dropped)
  );

  // Free-running clock, 4 ns period
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: reaching this means the block hung or lost a transaction
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d frame bytes still outstanding", bytes_pending);
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stretches with ready low while rx_idle is set, plus the long hold-off on request.
  // Ready changes only at the falling edge so the block samples a settled value.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < hold_requests) begin
        // Hold off for a long stretch so the pipeline fills and in_ready drops
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic scan_rec_t mk_rec(input logic [7:0] id, input logic [7:0] cyc,
                                       input logic [1:0] cnt,
                                       input logic [15:0] fc0, input logic [15:0] bl0,
                                       input logic [15:0] fc1, input logic [15:0] bl1);
    scan_rec_t r;
    r = {id, cyc, cnt, fc0, bl0, fc1, bl1};
    return r;
  endfunction

  // Mostly records inside the frame limit, the rest anywhere in the index range
  function automatic scan_rec_t random_rec(input logic [7:0] limit);
    scan_rec_t r;
    r.key_id           = 8'($urandom);
    r.element_count    = 2'($urandom_range(0, 3));
    r.filtered_count_0 = 16'($urandom);
    r.baseline_0       = ($urandom_range(0, 7) == 0) ? r.filtered_count_0 : 16'($urandom);
    r.filtered_count_1 = 16'($urandom);
    r.baseline_1       = ($urandom_range(0, 7) == 0) ? r.filtered_count_1 : 16'($urandom);
    if (limit != 8'd0 && $urandom_range(0, 99) < 85)
      r.cycle_index = 8'($urandom_range(0, int'(limit) - 1));
    else
      r.cycle_index = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Offer one record and hold it until the transaction completes
  task automatic drive_record(input scan_rec_t r);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 18)) @(negedge clk);
    end
    @(negedge clk);
    in_valid            <= 1'b1;
    in_key_id           <= r.key_id;
    in_cycle_index      <= r.cycle_index;
    in_element_count    <= r.element_count;
    in_filtered_count_0 <= r.filtered_count_0;
    in_baseline_0       <= r.baseline_0;
    in_filtered_count_1 <= r.filtered_count_1;
    in_baseline_1       <= r.baseline_1;
    do @(posedge clk); while (!in_ready);
    records_sent++;
  endtask

  // Wait for every predicted byte, then let any dropped record clear the pipeline
  task automatic wait_drained();
    while (bytes_pending != 0) @(negedge clk);
    repeat (DRAIN_GUARD) @(negedge clk);
  endtask

  // Write the frame limit only once the block is idle
  task automatic set_frame_limit(input logic [7:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    frame_limit_now = value;
    limit_writes++;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      drive_record(random_rec(frame_limit_now));
    end
  endtask

  initial begin
    // Initialise every input before the first edge
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = 8'h00;
    in_valid            = 1'b0;
    in_key_id           = 8'h00;
    in_cycle_index      = 8'h00;
    in_element_count    = 2'd0;
    in_filtered_count_0 = 16'h0000;
    in_baseline_0       = 16'h0000;
    in_filtered_count_1 = 16'h0000;
    in_baseline_1       = 16'h0000;
    records_sent        = 0;
    limit_writes        = 0;
    hold_requests       = 0;
    holds_done          = 0;
    tx_idle             = 1'b1;
    rx_idle             = 1'b1;
    frame_limit_now     = MAX_FRAMES_RESET;

    // Hold reset, then release it at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed records at the reset frame limit
    drive_record(mk_rec(8'h00, 8'd0, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // Widest deltas in both directions, last index below the limit
    drive_record(mk_rec(8'hFF, 8'd4, 2'd2, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
    // Element one absent although its inputs differ
    drive_record(mk_rec(8'h5A, 8'd3, 2'd1, 16'h1234, 16'h0234, 16'hBEEF, 16'h0001));
    // Element count of three is clamped to two
    drive_record(mk_rec(8'hA5, 8'd2, 2'd3, 16'h8000, 16'h7FFF, 16'h0001, 16'h0000));
    // Index at the limit and at the top of the range: consumed, no frame
    drive_record(mk_rec(8'h01, 8'd5, 2'd2, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
    drive_record(mk_rec(8'h02, 8'd255, 2'd2, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
    // Equal count and baseline give a zero delta
    drive_record(mk_rec(8'hC3, 8'd1, 2'd2, 16'h4321, 16'h4321, 16'h0000, 16'h0000));
    // No elements at all, inputs non-zero
    drive_record(mk_rec(8'h3C, 8'd0, 2'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
    drive_record(mk_rec(8'h7E, 8'd1, 2'd1, 16'h0000, 16'hFFFF, 16'h1111, 16'h2222));

    // Largest limit: only index 255 is dropped
    set_frame_limit(8'd255);
    drive_record(mk_rec(8'h81, 8'd254, 2'd2, 16'h0F0F, 16'hF0F0, 16'hF0F0, 16'h0F0F));
    drive_record(mk_rec(8'h82, 8'd255, 2'd2, 16'h1234, 16'h4321, 16'h0000, 16'h0001));
    drive_record(mk_rec(8'h83, 8'd0, 2'd2, 16'h0001, 16'h0000, 16'hFFFE, 16'hFFFF));

    // Zero limit: every record is dropped
    set_frame_limit(8'd0);
    drive_record(mk_rec(8'h84, 8'd0, 2'd2, 16'h0100, 16'h0001, 16'h0200, 16'h0002));
    drive_record(mk_rec(8'h85, 8'd0, 2'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    drive_record(mk_rec(8'h86, 8'd128, 2'd3, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));

    // Limit of one: only index zero passes
    set_frame_limit(8'd1);
    drive_record(mk_rec(8'h90, 8'd0, 2'd2, 16'hCAFE, 16'hBABE, 16'h0000, 16'hFFFF));
    drive_record(mk_rec(8'h91, 8'd1, 2'd2, 16'hCAFE, 16'hBABE, 16'h0000, 16'hFFFF));

    // Random records, idling on both sides
    set_frame_limit(8'd200);
    run_random(50);

    // Back-to-back records against a long receiver hold-off
    set_frame_limit(8'($urandom_range(1, 254)));
    tx_idle = 1'b0;
    hold_requests++;
    run_random(40);
    tx_idle = 1'b1;

    set_frame_limit(8'd255);
    run_random(50);

    // Closing stretch back at the reset limit with no idling at all
    set_frame_limit(MAX_FRAMES_RESET);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_random(40);

    // Drop valid and let everything drain
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();

    $display("Sent %0d records (%0d dropped by the frame limit) over %0d limit writes",
             records_sent, records_dropped, limit_writes);
    $display("Checked %0d frame bytes, %0d mismatches", bytes_checked, mismatches);
    if (mismatches == 0 && bytes_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sensor_delta_frame_encoder_top.f]
hw/rtl/sdfe_pkg.sv
hw/rtl/sdfe_delta.sv
hw/rtl/sdfe_crc_stage.sv
hw/rtl/sdfe_serializer.sv
hw/rtl/sensor_delta_frame_encoder_top.sv
dv/sdfe_frame_checker.sv
dv/tb_sensor_delta_frame_encoder_top.sv
